[hw/rtl/hcd_pkg.sv]
// shared types, constants and helper functions for the http chunk deframer
`default_nettype none

package hcd_pkg;

    // default limit on hex digits in one chunk size line
    localparam int unsigned DefMaxSizeDigits = 8;

    localparam logic [7:0] ChCr = 8'h0d;
    localparam logic [7:0] ChLf = 8'h0a;

    // decoder phase, one-hot
    typedef enum logic [7:0] {
        PH_HEADER  = 8'b0000_0001,
        PH_RAW     = 8'b0000_0010,
        PH_SIZE    = 8'b0000_0100,
        PH_SIZE_LF = 8'b0000_1000,
        PH_DATA    = 8'b0001_0000,
        PH_DATA_CR = 8'b0010_0000,
        PH_DATA_LF = 8'b0100_0000,
        PH_STOP    = 8'b1000_0000
    } t_phase;

    // framing control state carried between items
    typedef struct packed {
        t_phase     phase;
        logic [1:0] header_match;
        logic       header_pattern;
    } t_ctl;

    // flags of one result item
    typedef struct packed {
        logic has_result;
        logic body_valid;
        logic body_done;
        logic format_error;
    } t_flags;

    // hex digit decode: bit 4 is the ok flag, bits 3:0 the value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hcd_step.sv]
// next-state and result logic for one response byte
`default_nettype none

module hcd_step
    import hcd_pkg::*;
#(
    parameter int unsigned MAX_SIZE_DIGITS = DefMaxSizeDigits,
    localparam int unsigned RemW = 4 * MAX_SIZE_DIGITS,
    localparam int unsigned DigW = $clog2(MAX_SIZE_DIGITS + 1)
) (
    input  wire logic            i_chunked_mode,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire t_ctl            i_ctl,
    input  wire logic [RemW-1:0] i_rem,
    input  wire logic [DigW-1:0] i_digits,
    output t_ctl                 o_ctl,
    output logic      [RemW-1:0] o_rem,
    output logic      [DigW-1:0] o_digits,
    output t_flags               o_flags,
    output logic      [7:0]      o_body_byte
);

    localparam logic [DigW-1:0] MaxDigits = DigW'(MAX_SIZE_DIGITS);

    logic       is_cr;
    logic       is_lf;
    logic [4:0] hex;
    logic       last_kind;
    logic       valid;
    logic       done;
    logic       err;

    assign is_cr = (i_byte == ChCr);
    assign is_lf = (i_byte == ChLf);
    assign hex   = hex_digit(i_byte);
    // kind of the newest byte in the current cr/lf run
    assign last_kind = i_ctl.header_pattern ^ ~i_ctl.header_match[0];

    always_comb begin
        o_ctl    = i_ctl;
        o_rem    = i_rem;
        o_digits = i_digits;
        valid    = 1'b0;
        done     = 1'b0;
        err      = 1'b0;

        unique case (i_ctl.phase)
            PH_HEADER: begin
                if (!is_cr && !is_lf) begin
                    o_ctl.header_match = 2'd0;
                end else if (i_ctl.header_match != 2'd0 && is_lf != last_kind) begin
                    // run keeps alternating
                    if (i_ctl.header_match == 2'd3) begin
                        o_ctl.header_match = 2'd0;
                        o_ctl.phase = i_chunked_mode ? PH_SIZE : PH_RAW;
                    end else begin
                        o_ctl.header_match = i_ctl.header_match + 2'd1;
                    end
                end else begin
                    o_ctl.header_pattern = is_lf;
                    o_ctl.header_match   = 2'd1;
                end
            end
            PH_RAW: begin
                valid = 1'b1;
            end
            PH_SIZE: begin
                if (is_cr) begin
                    if (i_digits == '0) begin
                        err = 1'b1;
                    end else begin
                        o_ctl.phase = PH_SIZE_LF;
                    end
                end else if (!hex[4] || i_digits >= MaxDigits) begin
                    err = 1'b1;
                end else begin
                    o_rem    = (i_rem << 4) | RemW'(hex[3:0]);
                    o_digits = i_digits + DigW'(1);
                end
            end
            PH_SIZE_LF: begin
                if (!is_lf) begin
                    err = 1'b1;
                end else if (i_rem == '0) begin
                    // terminal chunk
                    done        = 1'b1;
                    o_ctl.phase = PH_STOP;
                end else begin
                    o_digits    = '0;
                    o_ctl.phase = PH_DATA;
                end
            end
            PH_DATA: begin
                valid = 1'b1;
                if (i_rem != '0) begin
                    o_rem = i_rem - RemW'(1);
                end
                if (i_rem <= RemW'(1)) begin
                    o_ctl.phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (!is_cr) begin
                    err = 1'b1;
                end else begin
                    o_ctl.phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (!is_lf) begin
                    err = 1'b1;
                end else begin
                    o_rem       = '0;
                    o_digits    = '0;
                    o_ctl.phase = PH_SIZE;
                end
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase

        if (err) begin
            o_ctl.phase = PH_STOP;
        end
        // end of response returns everything to reset
        if (i_last) begin
            done                 = 1'b1;
            o_ctl.phase          = PH_HEADER;
            o_ctl.header_match   = 2'd0;
            o_ctl.header_pattern = 1'b0;
            o_rem                = '0;
            o_digits             = '0;
        end
    end

    assign o_flags.has_result   = valid | done | err;
    assign o_flags.body_valid   = valid;
    assign o_flags.body_done    = done;
    assign o_flags.format_error = err;
    assign o_body_byte          = valid ? i_byte : 8'd0;

endmodule

`default_nettype wire

[hw/rtl/http_response_chunk_deframer.sv]
// top level of the http response chunk deframer
//
// channel  dir  handshake              payload
// s        in   i_s_tvalid/o_s_tready  tdata: in_byte[7:0]; tlast: in_last
// m        out  o_m_tvalid/i_m_tready  tdata: body_byte[7:0]; tlast: body_done;
//                                      tuser: body_valid[0], format_error[1]
// cfg      in   i_cfg_wr_en            i_cfg_wr_data: chunked_mode
//
// one byte per cycle sustained unless the output stalls; a byte is held in
// the input register and its result, if any, is registered in the output
// register. the framing state update is a single combinational pass, so bytes
// follow back to back. a stalled output holds the pipeline; the input register
// is refilled in the same cycle the output is taken. synchronous active-low
// reset clears the framing state and chunked_mode.
`default_nettype none

module http_response_chunk_deframer
    import hcd_pkg::*;
#(
    parameter int unsigned MAX_SIZE_DIGITS = DefMaxSizeDigits,
    localparam int unsigned RemW = 4 * MAX_SIZE_DIGITS,
    localparam int unsigned DigW = $clog2(MAX_SIZE_DIGITS + 1)
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    // response byte stream
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,
    // decoded body stream
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic      [7:0] o_m_tdata,   // [7:0] body_byte
    output logic      [1:0] o_m_tuser,   // [0] body_valid, [1] format_error
    output logic            o_m_tlast
);

    logic            r_mode;
    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    t_ctl            r_ctl;
    logic [RemW-1:0] r_rem;
    logic [DigW-1:0] r_digits;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic [1:0]      r_out_user;
    logic            r_out_last;

    t_ctl            n_ctl;
    logic [RemW-1:0] n_rem;
    logic [DigW-1:0] n_digits;
    t_flags          step_flags;
    logic [7:0]      step_byte;
    logic            advance;
    logic            process;

    // pipeline moves when the output register is free or being emptied
    assign advance    = !r_out_valid || i_m_tready;
    assign process    = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    hcd_step #(
        .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
    ) u_step (
        .i_chunked_mode(r_mode),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_ctl         (r_ctl),
        .i_rem         (r_rem),
        .i_digits      (r_digits),
        .o_ctl         (n_ctl),
        .o_rem         (n_rem),
        .o_digits      (n_digits),
        .o_flags       (step_flags),
        .o_body_byte   (step_byte)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase          <= PH_HEADER;
            r_ctl.header_match   <= 2'd0;
            r_ctl.header_pattern <= 1'b0;
            r_rem                <= '0;
            r_digits             <= '0;
        end else if (process) begin
            r_ctl    <= n_ctl;
            r_rem    <= n_rem;
            r_digits <= n_digits;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && step_flags.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_byte <= step_byte;
            r_out_user <= {step_flags.format_error, step_flags.body_valid};
            r_out_last <= step_flags.body_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    // a result never carries a body byte and an error together
    a_no_valid_and_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("body byte flagged together with format error");

    // bytes that are not body bytes go out as zero
    a_zero_non_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == 8'd0))
        else $error("non-body result carries a nonzero byte");

    // inside a chunk there is always at least one byte left
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.phase == PH_DATA) |-> (r_rem != '0))
        else $error("data phase with empty chunk count");

    // digit count never passes the limit
    a_digit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= DigW'(MAX_SIZE_DIGITS))
        else $error("size digit count beyond limit");

    // a stalled output register blocks the step from overwriting it
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_out_user)))
        else $error("pending result lost while stalled");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// testbench for the http response chunk deframer: directed and random responses
`default_nettype none

module tb_top;
    import hcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SizeDigitLimit = DefMaxSizeDigits;

    // one decoded result item
    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       body_done;
        logic       format_error;
    } t_body_item;

    // ways a random response is spoiled
    typedef enum int {
        FLT_NONE,
        FLT_OVERSIZE,
        FLT_EMPTY,
        FLT_EXTENSION,
        FLT_NO_CRLF,
        FLT_HUGE_CUT,
        FLT_TRUNCATE,
        FLT_CORRUPT,
        FLT_NOISE
    } t_fault;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // [7:0] in_byte
    logic       i_s_tlast = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] body_byte
    logic [1:0] o_m_tuser;           // [0] body_valid, [1] format_error
    logic       o_m_tlast;

    http_response_chunk_deframer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    // decoder copy kept by the testbench
    logic                          cfg_chunked = 1'b0;
    t_phase                        dec_phase = PH_HEADER;
    logic [1:0]                    hdr_run = 2'd0;
    logic                          hdr_first = 1'b0;
    logic [4*SizeDigitLimit-1:0]   dec_left = '0;
    int unsigned                   dec_digits = 0;

    t_body_item  expected_body[$];
    logic [7:0]  resp_bytes[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    bit          idle_on = 1'b0;
    bit          calm = 1'b0;
    int unsigned receiver_hold = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void clear_decoder();
        dec_phase  = PH_HEADER;
        hdr_run    = 2'd0;
        hdr_first  = 1'b0;
        dec_left   = '0;
        dec_digits = 0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // track alternating cr/lf run, true when the fourth one lands
    function automatic bit scan_header(input logic [7:0] c);
        logic is_lf;
        logic prev_lf;
        if (c != ChCr && c != ChLf) begin
            hdr_run = 2'd0;
            return 1'b0;
        end
        is_lf = (c == ChLf);
        if (hdr_run != 2'd0) begin
            prev_lf = hdr_first ^ ~hdr_run[0];
            if (is_lf != prev_lf) begin
                if (hdr_run == 2'd3) begin
                    hdr_run = 2'd0;
                    return 1'b1;
                end
                hdr_run = hdr_run + 2'd1;
                return 1'b0;
            end
        end
        hdr_first = is_lf;
        hdr_run   = 2'd1;
        return 1'b0;
    endfunction

    // advance the decoder by one byte, true when a result item is due
    function automatic bit decode_byte(input logic [7:0] c, input logic last,
                                       output t_body_item res);
        bit is_body;
        bit is_done;
        bit is_err;
        int d;
        is_body = 1'b0;
        is_done = 1'b0;
        is_err  = 1'b0;
        case (dec_phase)
            PH_HEADER: begin
                if (scan_header(c)) dec_phase = cfg_chunked ? PH_SIZE : PH_RAW;
            end
            PH_RAW: begin
                is_body = 1'b1;
            end
            PH_SIZE: begin
                if (c == ChCr) begin
                    if (dec_digits == 0) is_err = 1'b1;
                    else dec_phase = PH_SIZE_LF;
                end else begin
                    d = hex_nibble(c);
                    if (d < 0 || dec_digits >= SizeDigitLimit) begin
                        is_err = 1'b1;
                    end else begin
                        dec_left   = (dec_left << 4) | (4*SizeDigitLimit)'(d);
                        dec_digits = dec_digits + 1;
                    end
                end
            end
            PH_SIZE_LF: begin
                if (c != ChLf) begin
                    is_err = 1'b1;
                end else if (dec_left == '0) begin
                    is_done   = 1'b1;
                    dec_phase = PH_STOP;
                end else begin
                    dec_digits = 0;
                    dec_phase  = PH_DATA;
                end
            end
            PH_DATA: begin
                is_body = 1'b1;
                if (dec_left != '0) dec_left = dec_left - (4*SizeDigitLimit)'(1);
                if (dec_left == '0) dec_phase = PH_DATA_CR;
            end
            PH_DATA_CR: begin
                if (c != ChCr) is_err = 1'b1;
                else dec_phase = PH_DATA_LF;
            end
            PH_DATA_LF: begin
                if (c != ChLf) begin
                    is_err = 1'b1;
                end else begin
                    dec_left   = '0;
                    dec_digits = 0;
                    dec_phase  = PH_SIZE;
                end
            end
            default: ;
        endcase
        if (is_err) dec_phase = PH_STOP;
        if (last) begin
            is_done = 1'b1;
            clear_decoder();
        end
        res.body_byte    = is_body ? c : 8'h00;
        res.body_valid   = is_body;
        res.body_done    = is_done;
        res.format_error = is_err;
        return is_body || is_done || is_err;
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_body_item res;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        if (decode_byte(b, last, res)) expected_body.push_back(res);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], end_last && (i == s.len() - 1));
        end
    endtask

    task automatic send_response();
        for (int i = 0; i < resp_bytes.size(); i++) begin
            send_byte(resp_bytes[i], i == resp_bytes.size() - 1);
        end
    endtask

    // stop offering and let every expected item come out
    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        while (expected_body.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic chunked);
        wait_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= chunked;
        @(posedge i_clk);
        cfg_chunked = chunked;
        i_cfg_wr_en <= 1'b0;
    endtask

    // response builders
    function automatic void push_crlf();
        resp_bytes.push_back(ChCr);
        resp_bytes.push_back(ChLf);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + 8'(n);
        return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    // size digits, high nibble first, padded with leading zeros
    function automatic void push_size(input logic [31:0] v, input int width);
        for (int i = width - 1; i >= 0; i--) begin
            resp_bytes.push_back(hex_char(4'(v >> (4 * i))));
        end
    endfunction

    function automatic int hex_width(input logic [31:0] v);
        int w;
        w = 1;
        while (w < 8 && (v >> (4 * w)) != 0) w++;
        return w;
    endfunction

    function automatic void push_header();
        bit lf_first;
        int lines;
        lf_first = 1'($urandom_range(0, 1));
        lines    = $urandom_range(0, 2);
        for (int l = 0; l < lines; l++) begin
            repeat ($urandom_range(1, 8))
                resp_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
            if (lf_first) resp_bytes.push_back(ChLf);
            else push_crlf();
        end
        if (lines == 0 && !lf_first) push_crlf();
        if (lines == 0 && lf_first) resp_bytes.push_back(ChLf);
        push_crlf();
        if (lf_first) resp_bytes.push_back(ChCr);
    endfunction

    function automatic void spoil_tail(input t_fault f);
        int cut;
        if (f == FLT_TRUNCATE) begin
            cut = $urandom_range(1, resp_bytes.size());
            while (resp_bytes.size() > cut) void'(resp_bytes.pop_back());
        end else if (f == FLT_CORRUPT) begin
            resp_bytes[$urandom_range(0, resp_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void build_raw(input t_fault f);
        resp_bytes.delete();
        push_header();
        repeat ($urandom_range(0, 30)) resp_bytes.push_back(8'($urandom_range(0, 255)));
        spoil_tail(f);
    endfunction

    function automatic void build_chunked(input t_fault f);
        int          chunks;
        logic [31:0] sz;
        int          w;
        resp_bytes.delete();
        push_header();
        chunks = $urandom_range(1, 3);
        for (int k = 0; k < chunks; k++) begin
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            w  = hex_width(sz);
            if ($urandom_range(0, 4) == 0) w = 8;
            else w = w + $urandom_range(0, 8 - w < 2 ? 8 - w : 2);
            if (k == 0 && f == FLT_OVERSIZE) begin
                push_size(sz, 8);
                repeat ($urandom_range(1, 3))
                    resp_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            end else if (k == 0 && f == FLT_HUGE_CUT) begin
                // wide size, response cut off inside the chunk
                push_size($urandom | 32'h0000_0100, 8);
                push_crlf();
                repeat ($urandom_range(1, 6)) resp_bytes.push_back(8'($urandom_range(0, 255)));
                return;
            end else if (!(k == 0 && f == FLT_EMPTY)) begin
                push_size(sz, w);
            end
            if (k == 0 && f == FLT_EXTENSION) begin
                resp_bytes.push_back(";");
                resp_bytes.push_back("x");
            end
            push_crlf();
            repeat (sz) resp_bytes.push_back(8'($urandom_range(0, 255)));
            if (k == 0 && f == FLT_NO_CRLF) resp_bytes.push_back(8'($urandom_range(0, 255)));
            push_crlf();
        end
        // terminal chunk and optional trailer
        push_size(32'd0, $urandom_range(1, 3));
        push_crlf();
        repeat ($urandom_range(0, 3)) resp_bytes.push_back(8'($urandom_range(0, 255)));
        spoil_tail(f);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_body_item got;
        t_body_item want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata, o_m_tuser[0], o_m_tlast, o_m_tuser[1]};
            if (expected_body.size() == 0) begin
                $error("unexpected result item: byte %02h valid %0d done %0d error %0d",
                       got.body_byte, got.body_valid, got.body_done, got.format_error);
                mismatch_count++;
            end else begin
                want = expected_body.pop_front();
                if (got.body_byte !== want.body_byte) begin
                    $error("body_byte: expected %02h, got %02h", want.body_byte, got.body_byte);
                    mismatch_count++;
                end
                if (got.body_valid !== want.body_valid) begin
                    $error("body_valid: expected %0d, got %0d", want.body_valid,
                           got.body_valid);
                    mismatch_count++;
                end
                if (got.body_done !== want.body_done) begin
                    $error("body_done: expected %0d, got %0d", want.body_done, got.body_done);
                    mismatch_count++;
                end
                if (got.format_error !== want.format_error) begin
                    $error("format_error: expected %0d, got %0d", want.format_error,
                           got.format_error);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls plus a counted long hold-off on request
    initial begin : receiver
        int unsigned stall;
        forever begin
            @(posedge i_clk);
            if (receiver_hold != 0) begin
                i_m_tready <= 1'b0;
                for (int n = 0; n < receiver_hold; n++) @(posedge i_clk);
                receiver_hold = 0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 11);
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // raw body right after reset, lf-first terminator, byte extremes
    task automatic test_raw_body();
        send_text("\n\r\n\r", 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // one chunk, terminal chunk, trailer byte ignored
    task automatic test_chunk_framing();
        set_mode(1'b1);
        send_text("\r\n\r\n1\r\n", 1'b0);
        send_byte(8'h5a, 1'b0);
        send_text("\r\n0\r\nt", 1'b1);
    endtask

    // mixed hex case then extension, empty size line, too many leading zeros
    task automatic test_size_line_faults();
        send_text("\r\n\r\naF;q", 1'b1);
        send_text("\r\n\r\n\r", 1'b1);
        send_text("\r\n\r\n000000001", 1'b1);
    endtask

    // input ends inside the header
    task automatic test_early_end();
        send_text("HT", 1'b1);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_receiver_holdoff();
        set_mode(1'b0);
        idle_on = 1'b0;
        resp_bytes.delete();
        push_header();
        repeat (60) resp_bytes.push_back(8'($urandom_range(0, 255)));
        receiver_hold = 200;
        send_response();
        wait_quiet();
    endtask

    task automatic test_random_responses(input int n_items);
        int     start;
        int     pick;
        t_fault f;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if (!calm) idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 72) f = FLT_NONE;
            else if (pick < 75) f = FLT_NOISE;
            else f = t_fault'($urandom_range(int'(FLT_OVERSIZE), int'(FLT_CORRUPT)));
            if (f == FLT_NOISE) begin
                resp_bytes.delete();
                repeat ($urandom_range(1, 20)) resp_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (cfg_chunked) begin
                build_chunked(f);
            end else begin
                build_raw(f);
            end
            send_response();
            // sender pause until everything is out
            if ($urandom_range(0, 9) == 0) wait_quiet();
        end
    endtask

    // main sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_raw_body();
        test_chunk_framing();
        test_size_line_faults();
        test_early_end();
        test_receiver_holdoff();
        set_mode(1'b1);
        test_random_responses(700);
        set_mode(1'b0);
        test_random_responses(300);
        set_mode(1'b1);
        test_random_responses(700);
        // last stretch with no idling on either side
        calm = 1'b1;
        idle_on = 1'b0;
        test_random_responses(300);
        wait_quiet();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
